>>> rtl/bsn_pkg.sv
`timescale 1ns / 1ps

package bsn_pkg;

    // width of one value to be sorted
    localparam int VALUE_W = 32;

    // depth of the request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // one queued request: the value and whether it closes a batch
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_item;

endpackage

>>> rtl/balanced_sorting_network.sv
`timescale 1ns / 1ps
// flow: the request that completes a batch passes the queue and the store, then the network
//   runs block by block and phase by phase, then the COUNT results follow as an unbroken run
// throughput: one request per cycle while loading; while a batch sorts and emits, the
//   queue holds up to Q_DEPTH further requests; batch time is set by the single store and
//   one network phase per cycle with COUNT/2 comparators
// reset: synchronous active low, clears counters, queue and state; the receiver cannot stall
module balanced_sorting_network #(
    parameter int COUNT      = 16,
    parameter int LOG2_COUNT = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request side: taken when start is high and busy is low
    input  logic                               start,
    output logic                               busy,
    input  logic signed [bsn_pkg::VALUE_W-1:0] i_sample_value,
    // result side: one value per strobe, ascending, last one marked
    output logic                               o_strobe,
    output logic signed [bsn_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                               o_is_last
);
    import bsn_pkg::*;

    // front to queue
    logic  w_push;
    t_item w_push_item;
    logic  w_full;

    // queue to back
    logic  w_pop_valid;
    logic  w_pop_ready;
    t_item w_pop_item;

    // busy only while the queue is full, as it fills while the back is sorting or emitting
    assign busy = w_full;

    // front: takes requests and tags the one that closes a batch
    bsn_front #(
        .COUNT (COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sample_value (i_sample_value),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    // short queue so front and back stall independently
    bsn_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop_ready (w_pop_ready),
        .o_pop_valid (w_pop_valid),
        .o_pop_item  (w_pop_item)
    );

    // back: loads the store, runs the network phase by phase, emits in order
    bsn_back #(
        .COUNT      (COUNT),
        .LOG2_COUNT (LOG2_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_pop_valid),
        .i_item         (w_pop_item),
        .o_ready        (w_pop_ready),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_is_last      (o_is_last)
    );

endmodule

>>> rtl/bsn_front.sv
`timescale 1ns / 1ps

module bsn_front #(
    parameter int COUNT = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [bsn_pkg::VALUE_W-1:0] i_sample_value,
    input  logic                           i_full,
    output logic                           o_push,
    output bsn_pkg::t_item                 o_item
);
    import bsn_pkg::*;

    localparam int CW = $clog2(COUNT);

    logic [CW-1:0] r_load;
    logic [CW-1:0] n_load;
    logic          w_last;

    // a request is taken whenever the queue has room
    assign o_push = i_start && !i_full;
    assign w_last = (r_load == CW'(COUNT - 1));

    assign o_item.value = i_sample_value;
    assign o_item.last  = w_last;

    always_comb begin
        n_load = r_load;
        if (o_push) begin
            n_load = w_last ? '0 : r_load + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
        end else begin
            r_load <= n_load;
        end
    end

endmodule

>>> rtl/bsn_queue.sv
`timescale 1ns / 1ps

module bsn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsn_pkg::t_item i_push_item,
    output logic           o_full,
    input  logic           i_pop_ready,
    output logic           o_pop_valid,
    output bsn_pkg::t_item o_pop_item
);
    import bsn_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic              w_pop;

    assign o_full      = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_item  = r_mem[r_rp];
    assign w_pop       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/bsn_back.sv
`timescale 1ns / 1ps

module bsn_back #(
    parameter int COUNT      = 16,
    parameter int LOG2_COUNT = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  bsn_pkg::t_item                     i_item,
    output logic                               o_ready,
    output logic                               o_strobe,
    output logic signed [bsn_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                               o_is_last
);
    import bsn_pkg::*;

    localparam int IW   = $clog2(COUNT);
    localparam int PW   = (LOG2_COUNT > 1) ? $clog2(LOG2_COUNT) : 1;
    localparam int NCMP = COUNT / 2;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [VALUE_W-1:0] r_store [COUNT];
    logic signed [VALUE_W-1:0] n_store [COUNT];

    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_rd;
    logic [PW-1:0] r_phase;
    logic [PW-1:0] r_blk;
    logic          w_pop;
    logic          w_phase_end;
    logic          w_blk_end;

    // constant pairing per comparator and phase
    logic [IW-1:0] w_lo [NCMP][LOG2_COUNT];
    logic [IW-1:0] w_hi [NCMP][LOG2_COUNT];
    logic          w_ok [NCMP][LOG2_COUNT];

    for (genvar t = 0; t < NCMP; t++) begin : g_cmp
        for (genvar p = 0; p < LOG2_COUNT; p++) begin : g_ph
            localparam int GS   = COUNT >> p;
            localparam int HALF = GS / 2;
            localparam int DIVH = (HALF > 0) ? HALF : 1;
            localparam int G    = t / DIVH;
            localparam int GI   = t % DIVH;
            localparam int LO   = G * GS + GI;
            localparam int HI   = (G + 1) * GS - 1 - GI;
            localparam bit OK   = (HALF > 0) && (LO < COUNT) && (HI >= 0) && (HI < COUNT);
            assign w_lo[t][p] = IW'(LO);
            assign w_hi[t][p] = IW'(HI);
            assign w_ok[t][p] = OK;
        end
    end

    // one network phase: all pairs are disjoint, so they swap in parallel
    always_comb begin
        logic [IW-1:0] v_lo;
        logic [IW-1:0] v_hi;
        n_store = r_store;
        for (int t = 0; t < NCMP; t++) begin
            v_lo = w_lo[t][r_phase];
            v_hi = w_hi[t][r_phase];
            if (w_ok[t][r_phase] && (r_store[v_lo] > r_store[v_hi])) begin
                n_store[v_lo] = r_store[v_hi];
                n_store[v_hi] = r_store[v_lo];
            end
        end
    end

    assign o_ready     = (r_state == ST_LOAD);
    assign w_pop       = i_valid && o_ready;
    assign w_phase_end = (r_phase == PW'(LOG2_COUNT - 1));
    assign w_blk_end   = (r_blk == PW'(LOG2_COUNT - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_pop && i_item.last) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (w_phase_end && w_blk_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_rd == IW'(COUNT - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_store[r_wr] <= i_item.value;
        end else if (r_state == ST_SORT) begin
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        o_sorted_value <= r_store[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_wr      <= '0;
            r_rd      <= '0;
            r_phase   <= '0;
            r_blk     <= '0;
            o_strobe  <= 1'b0;
            o_is_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            o_strobe  <= (r_state == ST_EMIT);
            o_is_last <= (r_state == ST_EMIT) && (r_rd == IW'(COUNT - 1));
            if (w_pop) begin
                r_wr <= i_item.last ? '0 : r_wr + 1'b1;
            end
            if (r_state == ST_SORT) begin
                r_phase <= w_phase_end ? '0 : r_phase + 1'b1;
                if (w_phase_end) begin
                    r_blk <= w_blk_end ? '0 : r_blk + 1'b1;
                end
            end
            if (r_state == ST_EMIT) begin
                r_rd <= (r_rd == IW'(COUNT - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_last |-> o_strobe)
        else $error("last marker without strobe");

    a_emit_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT && w_phase_end && w_blk_end) |=> (r_rd == '0))
        else $error("emit does not start at entry zero");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !w_pop)
        else $error("request popped outside load");

    a_sort_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_item.last) |=> (r_phase == '0 && r_blk == '0 && r_wr == '0))
        else $error("network counters not clear at batch start");

endmodule

>>> tb/balanced_sorting_network_test.sv
`timescale 1ns / 1ps

// keeps the batch being loaded, sorts it when it fills and checks the emitted run
class sorted_run_checker #(int COUNT = 16, int LOG2_COUNT = 4);

    typedef logic signed [bsn_pkg::VALUE_W-1:0] t_value;

    t_value         loading_batch [COUNT];
    int             load_fill;
    bsn_pkg::t_item expected_run [$];
    int             failures;

    function new();
        load_fill = 0;
        failures  = 0;
    endfunction

    // balanced periodic network over the full batch, smaller value to the lower index
    function void sort_batch();
        int     grp;
        int     half;
        int     g;
        int     gi;
        int     lo;
        int     hi;
        t_value tmp;
        for (int blk = 0; blk < LOG2_COUNT; blk++) begin
            for (int ph = 0; ph < LOG2_COUNT; ph++) begin
                grp  = COUNT >> ph;
                half = grp / 2;
                if (half == 0) begin
                    continue;
                end
                for (int t = 0; t < COUNT / 2; t++) begin
                    g  = t / half;
                    gi = t % half;
                    lo = g * grp + gi;
                    hi = (g + 1) * grp - 1 - gi;
                    if (lo < COUNT && hi < COUNT && loading_batch[lo] > loading_batch[hi]) begin
                        tmp               = loading_batch[lo];
                        loading_batch[lo] = loading_batch[hi];
                        loading_batch[hi] = tmp;
                    end
                end
            end
        end
    endfunction

    function void note_request(t_value v);
        bsn_pkg::t_item item;
        loading_batch[load_fill] = v;
        load_fill++;
        if (load_fill == COUNT) begin
            sort_batch();
            for (int k = 0; k < COUNT; k++) begin
                item.value = loading_batch[k];
                item.last  = (k == COUNT - 1);
                expected_run.push_back(item);
            end
            load_fill = 0;
        end
    endfunction

    function void check_result(t_value v, logic last);
        bsn_pkg::t_item item;
        if (expected_run.size() == 0) begin
            $display("%0t: unexpected result value %0d last %0b", $time, v, last);
            failures++;
            return;
        end
        item = expected_run.pop_front();
        if (v !== item.value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time, item.value, v);
            failures++;
        end
        if (last !== item.last) begin
            $display("%0t: is_last expected %0b actual %0b", $time, item.last, last);
            failures++;
        end
    endfunction

    function int pending();
        return expected_run.size();
    endfunction

endclass

module balanced_sorting_network_test;

    localparam int COUNT       = 16;
    localparam int LOG2_COUNT  = 4;
    localparam int VALUE_W     = bsn_pkg::VALUE_W;
    // network plus a full emission plus some slack
    localparam int DRAIN_CYCLES = 2 * COUNT + LOG2_COUNT * LOG2_COUNT + 8;
    // no request and no result for this long means the block hung
    localparam int STALL_LIMIT  = 4000;
    localparam int BATCHES_PER_PHASE = 7;

    // content patterns for a random batch
    typedef enum int {
        BATCH_RANDOM,
        BATCH_NARROW,
        BATCH_ASCENDING,
        BATCH_DESCENDING,
        BATCH_CONSTANT,
        BATCH_EXTREMES,
        BATCH_KINDS
    } t_batch_kind;

    typedef logic signed [VALUE_W-1:0] t_value;

    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   start          = 1'b0;
    t_value i_sample_value = '0;
    logic   busy;
    logic   o_strobe;
    t_value o_sorted_value;
    logic   o_is_last;

    int     sender_idle_pct = 0;
    int     stall_cycles    = 0;

    sorted_run_checker #(COUNT, LOG2_COUNT) run_check;

    balanced_sorting_network #(
        .COUNT      (COUNT),
        .LOG2_COUNT (LOG2_COUNT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_value (i_sample_value),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_is_last      (o_is_last)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // everything is sampled at the edge, before the block's own updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // a result never comes from a request taken at the same edge
            if (o_strobe === 1'b1) begin
                run_check.check_result(o_sorted_value, o_is_last);
            end
            if (start === 1'b1 && busy === 1'b0) begin
                run_check.note_request(i_sample_value);
            end
        end
    end

    // count cycles with no progress on either side
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // one request: optional idle gap, then hold start until the block takes it
    task automatic send_sample(input t_value v);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_sample_value <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // a random boundary value or plain noise
    function automatic t_value pick_extreme();
        case ($urandom_range(5))
            0: return {1'b1, {(VALUE_W-1){1'b0}}};
            1: return {1'b0, {(VALUE_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            4: return t_value'(1);
            default: return t_value'($urandom);
        endcase
    endfunction

    // one full batch of the given shape
    task automatic send_batch(input t_batch_kind kind);
        t_value base;
        t_value stride;
        t_value v;
        base   = t_value'($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
        stride = t_value'($urandom_range(32'h0010_0000));
        for (int k = 0; k < COUNT; k++) begin
            case (kind)
                BATCH_NARROW:     v = t_value'($urandom_range(6)) - 3;
                // presorted and reverse sorted runs still go through the whole network
                BATCH_ASCENDING:  v = base + stride * k;
                BATCH_DESCENDING: v = base - stride * k;
                BATCH_CONSTANT:   v = base;
                BATCH_EXTREMES:   v = pick_extreme();
                default:          v = t_value'($urandom);
            endcase
            send_sample(v);
        end
    endtask

    initial begin
        t_value directed [COUNT];

        run_check = new();

        // reset once, then released
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed batch: both ends of the range, sign edges, alternating bits
        // and repeated values, which must not be exchanged out of order
        directed = '{
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
            32'sd1,         32'sh8000_0001, 32'sh7fff_fffe, 32'sh5555_5555,
            32'shaaaa_aaaa, 32'sd5,         32'sd5,         -32'sd5,
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'sh0001_0000
        };
        sender_idle_pct = 18;
        foreach (directed[k]) begin
            send_sample(directed[k]);
        end

        // random part: light sender gaps, heavy gaps, then back to back
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       sender_idle_pct = 18;
                1:       sender_idle_pct = 57;
                default: sender_idle_pct = 0;
            endcase
            for (int b = 0; b < BATCHES_PER_PHASE - (phase == 2); b++) begin
                // plain random content on 40 percent of draws, else any pattern, random included
                if ($urandom_range(99) < 40) begin
                    send_batch(BATCH_RANDOM);
                end else begin
                    send_batch(t_batch_kind'($urandom_range(BATCH_KINDS - 1)));
                end
            end
        end
        start <= 1'b0;

        // the watchdog covers a run that never drains
        while (run_check.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (run_check.failures == 0 && run_check.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
